### sv/rhrp_pkg.sv
package rhrp_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PANEL_WIDTH = 3'd0;
    localparam logic [2:0] REG_CENTER_COL  = 3'd1;
    localparam logic [2:0] REG_CENTER_ROW  = 3'd2;
    localparam logic [2:0] REG_PHASE_STEP  = 3'd3;
    localparam logic [2:0] REG_RING_SCALE  = 3'd4;

    // Reset values of the configuration registers
    localparam logic [6:0]  RST_PANEL_WIDTH = 7'd32;
    localparam logic [9:0]  RST_CENTER_COL  = 10'd248;
    localparam logic [9:0]  RST_CENTER_ROW  = 10'd248;
    localparam logic [15:0] RST_PHASE_STEP  = 16'd256;
    localparam logic [11:0] RST_RING_SCALE  = 12'd256;

    // Hue wheel
    localparam int unsigned HUE_STEPS  = 96;
    localparam int unsigned PHASE_WRAP = HUE_STEPS * 256;

    // Iteration counts of the shared subtractor
    localparam int unsigned SQRT_STEPS = 30;
    localparam int unsigned DIV_STEPS  = 18;

endpackage

### sv/radial_hue_ring_pixel.sv
// An accepted pixel beat passes through the multiply states, 30 square-root steps,
// 18 divide steps, the hue state and the output state before its result beat;
// an advance beat goes straight to the output state. One item in flight: the next is
// accepted once the result is moved to the output register.
// The shared compare-subtract unit produces one root or quotient bit per cycle.
// Reset (rst_n low, asynchronous): idle, phase zero, config registers at defaults.
module radial_hue_ring_pixel
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] pixel_col, [11:6] pixel_row, [15:12] zero
    input  logic [0:0]  s_tuser,   // [0] mode
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] hue_index, [7] frame_start
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MDX  = 4'd1;  // dx squared
    localparam logic [3:0] ST_MDY  = 4'd2;  // add dy squared
    localparam logic [3:0] ST_MAA  = 4'd3;  // A squared, A = scale*96
    localparam logic [3:0] ST_MLO  = 4'd4;  // low half of A*A times B
    localparam logic [3:0] ST_MHI  = 4'd5;  // high half, accumulate
    localparam logic [3:0] ST_SQRT = 4'd6;  // restoring square root
    localparam logic [3:0] ST_DIV  = 4'd7;  // divide root/4096 by width-1
    localparam logic [3:0] ST_HUE  = 4'd8;  // phase minus q, wrap
    localparam logic [3:0] ST_FIN  = 4'd9;  // hand result to output register

    localparam logic [4:0] SQRT_LAST = 5'(rhrp_pkg::SQRT_STEPS - 1);
    localparam logic [4:0] DIV_LAST  = 5'(rhrp_pkg::DIV_STEPS - 1);
    localparam logic [7:0] HUE_N8    = 8'(rhrp_pkg::HUE_STEPS);
    localparam logic [8:0] HUE_N9    = 9'(rhrp_pkg::HUE_STEPS);
    localparam logic [17:0] WRAP18   = 18'(rhrp_pkg::PHASE_WRAP);

    // Configuration registers
    logic [6:0]  panel_width_reg;
    logic [9:0]  center_col_reg;
    logic [9:0]  center_row_reg;
    logic [15:0] phase_step_reg;
    logic [11:0] ring_scale_reg;

    // Frame state
    logic [14:0] phase_reg, phase_next;

    // Sequencer and datapath
    logic [3:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [9:0]  dx_reg, dx_next;          // |dx| in sixteenths
    logic [9:0]  dy_reg, dy_next;
    logic [20:0] ssq_reg, ssq_next;        // dx*dx + dy*dy
    logic [37:0] a2_reg, a2_next;          // A*A
    logic [59:0] rad_reg, rad_next;        // radicand, shifts out two bits per step
    logic [31:0] rem_reg, rem_next;        // root remainder
    logic [29:0] root_reg, root_next;
    logic [17:0] dvd_reg, dvd_next;        // dividend in, quotient out
    logic [6:0]  drem_reg, drem_next;      // divide remainder
    logic [6:0]  qm_reg, qm_next;          // quotient mod 96
    logic [6:0]  res_hue_reg, res_hue_next;
    logic        res_fs_reg, res_fs_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;

    // Shared multiplier
    logic [18:0] mul_a;
    logic [21:0] mul_b;
    logic [40:0] mul_p;

    // Shared compare-subtract unit
    logic [33:0] sub_a;
    logic [33:0] sub_b;
    logic [34:0] sub_d;
    logic        sub_ge;

    // Helpers
    logic        accept;
    logic [10:0] dx_s, dy_s;
    logic [18:0] a_val;
    logic [21:0] b_val;
    logic [6:0]  wm1;
    logic [17:0] adv_sum;
    logic [17:0] adv_wrap;
    logic [7:0]  qm_t;
    logic [6:0]  ph_hi;
    logic        carry_up;
    logic [8:0]  hue_v;
    logic [8:0]  hue_w;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Signed offsets from the ring center; keep magnitudes for squaring
    assign dx_s = {1'b0, s_tdata[5:0], 4'b0000} - {1'b0, center_col_reg};
    assign dy_s = {1'b0, s_tdata[11:6], 4'b0000} - {1'b0, center_row_reg};

    // A = scale*96 = scale*64 + scale*32
    assign a_val = {1'b0, ring_scale_reg, 6'b0} + {2'b0, ring_scale_reg, 5'b0};
    assign b_val = {ssq_reg, 1'b0};

    // A width of 0 or 1 behaves as 2
    assign wm1 = (panel_width_reg < 7'd2) ? 7'd1 : (panel_width_reg - 7'd1);

    assign mul_p = 41'(mul_a) * 41'(mul_b);
    assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[34];

    // Advance: add signed step, wrap once
    assign adv_sum  = {3'b000, phase_reg} + {{2{phase_step_reg[15]}}, phase_step_reg};
    assign adv_wrap = adv_sum[17] ? (adv_sum + WRAP18)
                    : ((adv_sum >= WRAP18) ? (adv_sum - WRAP18) : adv_sum);

    // Quotient bit enters the running mod-96 remainder
    assign qm_t = {qm_reg, !sub_d[34]};

    // trunc(phase/256 - q): step up by one when negative with a nonzero fraction
    assign ph_hi    = phase_reg[14:8];
    assign carry_up = ({11'b0, ph_hi} < dvd_reg) && (phase_reg[7:0] != 8'd0);
    assign hue_v    = {2'b00, ph_hi} + {8'b0, carry_up} - {2'b00, qm_reg};
    assign hue_w    = hue_v[8] ? (hue_v + HUE_N9)
                    : ((hue_v >= HUE_N9) ? (hue_v - HUE_N9) : hue_v);

    always_comb
    begin
        case (state_reg)
            ST_MDX:
            begin
                mul_a = {9'b0, dx_reg};
                mul_b = {12'b0, dx_reg};
            end
            ST_MDY:
            begin
                mul_a = {9'b0, dy_reg};
                mul_b = {12'b0, dy_reg};
            end
            ST_MAA:
            begin
                mul_a = a_val;
                mul_b = {3'b000, a_val};
            end
            ST_MLO:
            begin
                mul_a = a2_reg[18:0];
                mul_b = b_val;
            end
            ST_MHI:
            begin
                mul_a = a2_reg[37:19];
                mul_b = b_val;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_SQRT:
            begin
                sub_a = {rem_reg, rad_reg[59:58]};
                sub_b = {2'b00, root_reg, 2'b01};
            end
            ST_DIV:
            begin
                sub_a = {26'b0, drem_reg, dvd_reg[17]};
                sub_b = {27'b0, wm1};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        ssq_next       = ssq_reg;
        a2_next        = a2_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        dvd_next       = dvd_reg;
        drem_next      = drem_reg;
        qm_next        = qm_reg;
        res_hue_next   = res_hue_reg;
        res_fs_next    = res_fs_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Drop the output beat once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0])
                    begin
                        phase_next   = adv_wrap[14:0];
                        res_hue_next = '0;
                        res_fs_next  = (adv_wrap[14:0] == 15'd0);
                        state_next   = ST_FIN;
                    end
                    else
                    begin
                        dx_next    = dx_s[10] ? 10'(-dx_s) : dx_s[9:0];
                        dy_next    = dy_s[10] ? 10'(-dy_s) : dy_s[9:0];
                        state_next = ST_MDX;
                    end
                end
            end
            ST_MDX:
            begin
                ssq_next   = {1'b0, mul_p[19:0]};
                state_next = ST_MDY;
            end
            ST_MDY:
            begin
                ssq_next   = ssq_reg + {1'b0, mul_p[19:0]};
                state_next = ST_MAA;
            end
            ST_MAA:
            begin
                a2_next    = mul_p[37:0];
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                rad_next   = {19'b0, mul_p};
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                rad_next   = rad_reg + {mul_p[40:0], 19'b0};
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                rad_next = {rad_reg[57:0], 2'b00};
                if (sub_ge)
                begin
                    rem_next  = sub_d[31:0];
                    root_next = {root_reg[28:0], 1'b1};
                end
                else
                begin
                    rem_next  = sub_a[31:0];
                    root_next = {root_reg[28:0], 1'b0};
                end
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                    // Dividend is root/4096; the root bit found now lies below it
                    dvd_next   = root_reg[28:11];
                    drem_next  = '0;
                    qm_next    = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DIV:
            begin
                dvd_next  = {dvd_reg[16:0], sub_ge};
                drem_next = sub_ge ? sub_d[6:0] : sub_a[6:0];
                qm_next   = (qm_t >= HUE_N8) ? 7'(qm_t - HUE_N8) : qm_t[6:0];
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_HUE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_HUE:
            begin
                res_hue_next = hue_w[6:0];
                res_fs_next  = 1'b0;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_fs_reg, res_hue_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg <= rhrp_pkg::RST_PANEL_WIDTH;
            center_col_reg  <= rhrp_pkg::RST_CENTER_COL;
            center_row_reg  <= rhrp_pkg::RST_CENTER_ROW;
            phase_step_reg  <= rhrp_pkg::RST_PHASE_STEP;
            ring_scale_reg  <= rhrp_pkg::RST_RING_SCALE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                rhrp_pkg::REG_PANEL_WIDTH: panel_width_reg <= cfg_data[6:0];
                rhrp_pkg::REG_CENTER_COL:  center_col_reg  <= cfg_data[9:0];
                rhrp_pkg::REG_CENTER_ROW:  center_row_reg  <= cfg_data[9:0];
                rhrp_pkg::REG_PHASE_STEP:  phase_step_reg  <= cfg_data;
                rhrp_pkg::REG_RING_SCALE:  ring_scale_reg  <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        ssq_reg      <= ssq_next;
        a2_reg       <= a2_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        dvd_reg      <= dvd_next;
        drem_reg     <= drem_next;
        qm_reg       <= qm_next;
        res_hue_reg  <= res_hue_next;
        res_fs_reg   <= res_fs_next;
        out_data_reg <= out_data_next;
    end

endmodule
